@@ rtl/tfn_pkg.sv @@
// Shared constants for the triangle face normal pipeline.
// No dependencies; imported by every module of the block.
`default_nettype none

package tfn_pkg;

  // Default field widths
  localparam int unsigned COORD_WIDTH_DEF = 24;
  localparam int unsigned INDEX_WIDTH_DEF = 16;

  // Result component width, signed Q1.15
  localparam int unsigned NORM_WIDTH = 16;
  localparam logic [NORM_WIDTH-1:0] NORM_MAX = 16'h7fff;

  // Quotient c^2 * 2^32 / S is at most 2^32: 33 bits, one stage per bit
  localparam int unsigned QUOT_SHIFT = 32;
  localparam int unsigned QUOT_BITS  = QUOT_SHIFT + 1;

  // Integer square root of the quotient: at most 2^16, one stage per bit
  localparam int unsigned ROOT_BITS = 17;

  // Register depth of the front-end modules
  localparam int unsigned CROSS_STAGES  = 3;
  localparam int unsigned SQUARE_STAGES = 3;

endpackage

`default_nettype wire

@@ rtl/tfn_cross.sv @@
// Edge vectors and cross product, three register stages.
// Depends on tfn_pkg.
`default_nettype none

module tfn_cross #(
  parameter int unsigned CW = tfn_pkg::COORD_WIDTH_DEF
) (
  input  wire                      clk_i,
  input  wire                      en_i,
  input  wire  signed [CW-1:0]     vtx_i [9],   // v0 xyz, v1 xyz, v2 xyz
  output logic        [2*CW:0]     mag_o [3],   // |c| per axis
  output logic        [2:0]        neg_o        // sign of c per axis
);
  import tfn_pkg::*;

  localparam int unsigned EW = CW + 1;      // edge width
  localparam int unsigned PW = 2 * EW;      // product / cross width
  localparam int unsigned MW = 2 * CW + 1;  // magnitude width

  logic signed [EW-1:0] e1_q [3];
  logic signed [EW-1:0] e2_q [3];
  logic signed [PW-1:0] prod_q [6];
  logic signed [PW-1:0] c_w [3];
  logic        [MW-1:0] mag_q [3];
  logic        [2:0]    neg_q;

  // Stage 1: edges e1 = v1 - v0, e2 = v2 - v0
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        e1_q[k] <= {vtx_i[3+k][CW-1], vtx_i[3+k]} - {vtx_i[k][CW-1], vtx_i[k]};
        e2_q[k] <= {vtx_i[6+k][CW-1], vtx_i[6+k]} - {vtx_i[k][CW-1], vtx_i[k]};
      end
    end
  end

  // Stage 2: six partial products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q[0] <= e1_q[1] * e2_q[2];
      prod_q[1] <= e1_q[2] * e2_q[1];
      prod_q[2] <= e1_q[2] * e2_q[0];
      prod_q[3] <= e1_q[0] * e2_q[2];
      prod_q[4] <= e1_q[0] * e2_q[1];
      prod_q[5] <= e1_q[1] * e2_q[0];
    end
  end

  // Stage 3: differences, split into sign and magnitude
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      c_w[k] = prod_q[2*k] - prod_q[2*k+1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        neg_q[k] <= c_w[k][PW-1];
        mag_q[k] <= c_w[k][PW-1] ? MW'(-c_w[k]) : MW'(c_w[k]);
      end
    end
  end

  assign mag_o = mag_q;
  assign neg_o = neg_q;

endmodule

`default_nettype wire

@@ rtl/tfn_square.sv @@
// Squares of the cross-product magnitudes and their sum, three stages.
// Each square is built from three half-width partial products. Uses tfn_pkg.
`default_nettype none

module tfn_square #(
  parameter int unsigned MW = 2 * tfn_pkg::COORD_WIDTH_DEF + 1
) (
  input  wire               clk_i,
  input  wire               en_i,
  input  wire  [MW-1:0]     mag_i [3],
  output logic [2*MW-1:0]   sq_o  [3],   // c^2 per axis
  output logic [2*MW+1:0]   sum_o        // S = sum of squares
);
  import tfn_pkg::*;

  localparam int unsigned LO = (MW + 1) / 2;
  localparam int unsigned HI = MW - LO;
  localparam int unsigned QW = 2 * MW;
  localparam int unsigned SW = 2 * MW + 2;

  logic [2*HI-1:0]  hh_q [3];
  logic [HI+LO-1:0] hl_q [3];
  logic [2*LO-1:0]  ll_q [3];
  logic [QW-1:0]    sq_q [3];
  logic [QW-1:0]    sq_out_q [3];
  logic [SW-1:0]    sum_q;

  // Stage 1: partial products of the high and low halves
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        hh_q[k] <= mag_i[k][MW-1:LO] * mag_i[k][MW-1:LO];
        hl_q[k] <= mag_i[k][MW-1:LO] * mag_i[k][LO-1:0];
        ll_q[k] <= mag_i[k][LO-1:0] * mag_i[k][LO-1:0];
      end
    end
  end

  // Stage 2: recombine, the cross term counts twice
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        sq_q[k] <= (QW'(hh_q[k]) << (2 * LO)) + (QW'(hl_q[k]) << (LO + 1))
                 + QW'(ll_q[k]);
      end
    end
  end

  // Stage 3: squared length, squares kept alongside
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_q    <= SW'(sq_q[0]) + SW'(sq_q[1]) + SW'(sq_q[2]);
      sq_out_q <= sq_q;
    end
  end

  assign sq_o  = sq_out_q;
  assign sum_o = sum_q;

endmodule

`default_nettype wire

@@ rtl/tfn_div.sv @@
// Pipelined restoring divider: floor(num * 2^32 / den), one quotient bit
// per stage. Requires num <= den. Depends on tfn_pkg.
`default_nettype none

module tfn_div #(
  parameter int unsigned NW = 2 * (2 * tfn_pkg::COORD_WIDTH_DEF + 1),
  parameter int unsigned SW = NW + 2
) (
  input  wire                              clk_i,
  input  wire                              en_i,
  input  wire  [NW-1:0]                    num_i,
  input  wire  [SW-1:0]                    den_i,
  output logic [tfn_pkg::QUOT_BITS-1:0]    quot_o
);
  import tfn_pkg::*;

  logic [SW-1:0]        rem_q [QUOT_BITS];
  logic [SW-1:0]        den_q [QUOT_BITS];
  logic [QUOT_BITS-1:0] quo_q [QUOT_BITS];

  logic [SW:0]   part_w [QUOT_BITS];
  logic [SW-1:0] dsrc_w [QUOT_BITS];
  logic [SW:0]   diff_w [QUOT_BITS];
  logic          ge_w   [QUOT_BITS];

  // Partial remainder of each stage: the first takes the numerator as is,
  // later ones shift in a zero
  always_comb begin
    part_w[0] = (SW + 1)'(num_i);
    dsrc_w[0] = den_i;
    for (int i = 1; i < QUOT_BITS; i++) begin
      part_w[i] = {rem_q[i-1], 1'b0};
      dsrc_w[i] = den_q[i-1];
    end
    for (int i = 0; i < QUOT_BITS; i++) begin
      diff_w[i] = part_w[i] - {1'b0, dsrc_w[i]};
      ge_w[i]   = ~diff_w[i][SW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= ge_w[0] ? diff_w[0][SW-1:0] : part_w[0][SW-1:0];
      den_q[0] <= dsrc_w[0];
      quo_q[0] <= QUOT_BITS'(ge_w[0]);
      for (int i = 1; i < QUOT_BITS; i++) begin
        rem_q[i] <= ge_w[i] ? diff_w[i][SW-1:0] : part_w[i][SW-1:0];
        den_q[i] <= dsrc_w[i];
        quo_q[i] <= {quo_q[i-1][QUOT_BITS-2:0], ge_w[i]};
      end
    end
  end

  assign quot_o = quo_q[QUOT_BITS-1];

endmodule

`default_nettype wire

@@ rtl/tfn_isqrt.sv @@
// Pipelined integer square root, one root bit per stage, adds only:
// (r + 2^b)^2 = r^2 + r * 2^(b+1) + 2^(2b). Depends on tfn_pkg.
`default_nettype none

module tfn_isqrt (
  input  wire                            clk_i,
  input  wire                            en_i,
  input  wire  [tfn_pkg::QUOT_BITS-1:0]  val_i,
  output logic [tfn_pkg::ROOT_BITS-1:0]  root_o
);
  import tfn_pkg::*;

  localparam int unsigned TW = 2 * ROOT_BITS + 1;

  logic [QUOT_BITS-1:0] val_q [ROOT_BITS];
  logic [ROOT_BITS-1:0] res_q [ROOT_BITS];
  logic [TW-1:0]        sq_q  [ROOT_BITS];

  logic [QUOT_BITS-1:0] vsrc_w [ROOT_BITS];
  logic [ROOT_BITS-1:0] rsrc_w [ROOT_BITS];
  logic [TW-1:0]        ssrc_w [ROOT_BITS];
  logic [TW-1:0]        trial_w [ROOT_BITS];
  logic                 fit_w [ROOT_BITS];

  // Trial square for the bit of each stage, most significant first
  always_comb begin
    int b;
    vsrc_w[0] = val_i;
    rsrc_w[0] = '0;
    ssrc_w[0] = '0;
    for (int j = 1; j < ROOT_BITS; j++) begin
      vsrc_w[j] = val_q[j-1];
      rsrc_w[j] = res_q[j-1];
      ssrc_w[j] = sq_q[j-1];
    end
    for (int j = 0; j < ROOT_BITS; j++) begin
      b = ROOT_BITS - 1 - j;
      trial_w[j] = ssrc_w[j] + (TW'(rsrc_w[j]) << (b + 1)) + (TW'(1) << (2 * b));
      fit_w[j]   = trial_w[j] <= TW'(vsrc_w[j]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < ROOT_BITS; j++) begin
        val_q[j] <= vsrc_w[j];
        res_q[j] <= fit_w[j] ? (rsrc_w[j] | (ROOT_BITS'(1) << (ROOT_BITS - 1 - j)))
                             : rsrc_w[j];
        sq_q[j]  <= fit_w[j] ? trial_w[j] : ssrc_w[j];
      end
    end
  end

  assign root_o = res_q[ROOT_BITS-1];

endmodule

`default_nettype wire

@@ rtl/triangle_face_normal_unit.sv @@
// Triangle face normal: cross product of the edges, normalised to Q1.15.
// From input transfer to result, a triangle passes the cross product, square
// and sum, divider (one quotient bit per stage), square root and output register.
// Throughput one triangle per cycle; a stall at the output freezes the whole
// pipeline. Reset (rst_ni low, asynchronous) empties the pipeline and clears
// min_len_q to zero. Depends on tfn_pkg and the tfn_* modules.
`default_nettype none

module triangle_face_normal_unit #(
  parameter int unsigned COORD_WIDTH = tfn_pkg::COORD_WIDTH_DEF,
  parameter int unsigned INDEX_WIDTH = tfn_pkg::INDEX_WIDTH_DEF
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  // Input stream; tdata from bit 0: v0_x, v0_y, v0_z, v1_x, v1_y, v1_z,
  // v2_x, v2_y, v2_z, triangle_index, zero fill
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [((9*COORD_WIDTH+INDEX_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  input  wire         s_axis_tlast,
  // Result stream; tdata from bit 0: tri_tag, normal_x, normal_y, normal_z,
  // zero fill
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [((INDEX_WIDTH+3*tfn_pkg::NORM_WIDTH+7)/8)*8-1:0] m_axis_tdata,
  output logic        m_axis_tlast,
  output logic        m_axis_tuser,   // degenerate
  // Threshold register write
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [31:0] cfg_data_i
);
  import tfn_pkg::*;

  localparam int unsigned CW   = COORD_WIDTH;
  localparam int unsigned IW   = INDEX_WIDTH;
  localparam int unsigned MW   = 2 * CW + 1;
  localparam int unsigned SW   = 2 * MW + 2;
  localparam int unsigned SWX  = (SW > 64) ? SW : 65;
  localparam int unsigned OW   = ((IW + 3 * NORM_WIDTH + 7) / 8) * 8;
  localparam int unsigned PIPE = CROSS_STAGES + SQUARE_STAGES + QUOT_BITS + ROOT_BITS;
  localparam int unsigned NEG_LEN = PIPE - CROSS_STAGES;
  localparam int unsigned DEG_LEN = PIPE - CROSS_STAGES - SQUARE_STAGES;

  logic                 en;
  logic [31:0]          min_len_q;

  logic signed [CW-1:0] vtx_w [9];
  logic [MW-1:0]        mag_w [3];
  logic [2:0]           neg_w;
  logic [2*MW-1:0]      sq_w [3];
  logic [SW-1:0]        sum_w;
  logic [SWX-1:0]       sum_ext;
  logic                 degen_w;
  logic [QUOT_BITS-1:0] quot_w [3];
  logic [ROOT_BITS-1:0] root_w [3];

  logic                 vld_q  [PIPE];
  logic                 last_q [PIPE];
  logic [IW-1:0]        tag_q  [PIPE];
  logic [2:0]           neg_q  [NEG_LEN];
  logic                 deg_q  [DEG_LEN];

  logic [ROOT_BITS:0]   rnd_w [3];
  logic [NORM_WIDTH-1:0] norm_w [3];
  logic [OW-1:0]        out_d;
  logic                 out_vld_q;
  logic [OW-1:0]        out_data_q;
  logic                 out_last_q;
  logic                 out_user_q;

  // Whole pipeline advances unless a result waits on a stalled output
  assign en            = ~out_vld_q | m_axis_tready;
  assign s_axis_tready = en;

  // Threshold register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_len_q <= '0;
    end else if (cfg_valid_i) begin
      min_len_q <= cfg_data_i;
    end
  end

  // Unpack vertices
  always_comb begin
    for (int k = 0; k < 9; k++) begin
      vtx_w[k] = s_axis_tdata[k*CW +: CW];
    end
  end

  tfn_cross #(.CW(CW)) u_cross (
    .clk_i (clk_i),
    .en_i  (en),
    .vtx_i (vtx_w),
    .mag_o (mag_w),
    .neg_o (neg_w)
  );

  tfn_square #(.MW(MW)) u_square (
    .clk_i (clk_i),
    .en_i  (en),
    .mag_i (mag_w),
    .sq_o  (sq_w),
    .sum_o (sum_w)
  );

  // Degenerate: zero squared length, or squared length >> 32 below the threshold
  always_comb begin
    sum_ext = SWX'(sum_w);
    degen_w = (sum_w == '0)
            || ((sum_ext[SWX-1:64] == '0) && (sum_ext[63:32] < min_len_q));
  end

  for (genvar k = 0; k < 3; k++) begin : g_axis
    tfn_div #(.NW(2 * MW), .SW(SW)) u_div (
      .clk_i  (clk_i),
      .en_i   (en),
      .num_i  (sq_w[k]),
      .den_i  (sum_w),
      .quot_o (quot_w[k])
    );

    tfn_isqrt u_isqrt (
      .clk_i  (clk_i),
      .en_i   (en),
      .val_i  (quot_w[k]),
      .root_o (root_w[k])
    );
  end

  // Valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < PIPE; p++) begin
        vld_q[p] <= 1'b0;
      end
    end else if (en) begin
      vld_q[0] <= s_axis_tvalid;
      for (int p = 1; p < PIPE; p++) begin
        vld_q[p] <= vld_q[p-1];
      end
    end
  end

  // Sideband delay lines: tag and last from entry, sign after the cross
  // product, degenerate flag after the sum
  always_ff @(posedge clk_i) begin
    if (en) begin
      tag_q[0]  <= s_axis_tdata[9*CW +: IW];
      last_q[0] <= s_axis_tlast;
      for (int p = 1; p < PIPE; p++) begin
        tag_q[p]  <= tag_q[p-1];
        last_q[p] <= last_q[p-1];
      end
      neg_q[0] <= neg_w;
      for (int p = 1; p < NEG_LEN; p++) begin
        neg_q[p] <= neg_q[p-1];
      end
      deg_q[0] <= degen_w;
      for (int p = 1; p < DEG_LEN; p++) begin
        deg_q[p] <= deg_q[p-1];
      end
    end
  end

  // Round to nearest (m = (root + 1) / 2), apply sign, saturate +1.0, zero if degenerate
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rnd_w[k] = (ROOT_BITS + 1)'(root_w[k]) + (ROOT_BITS + 1)'(1);
      if (deg_q[DEG_LEN-1]) begin
        norm_w[k] = '0;
      end else if (neg_q[NEG_LEN-1][k]) begin
        norm_w[k] = -rnd_w[k][NORM_WIDTH:1];
      end else if (rnd_w[k][ROOT_BITS:1] > (ROOT_BITS)'(NORM_MAX)) begin
        norm_w[k] = NORM_MAX;
      end else begin
        norm_w[k] = rnd_w[k][NORM_WIDTH:1];
      end
    end
    out_d = '0;
    out_d[IW-1:0] = tag_q[PIPE-1];
    for (int k = 0; k < 3; k++) begin
      out_d[IW + k*NORM_WIDTH +: NORM_WIDTH] = norm_w[k];
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= vld_q[PIPE-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= out_d;
      out_last_q <= last_q[PIPE-1];
      out_user_q <= deg_q[DEG_LEN-1];
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_user_q;

`ifndef ASSERT_OFF
  // A degenerate triangle carries an all-zero normal
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[IW +: 3*NORM_WIDTH] == '0))
    else $error("degenerate result with non-zero normal");

  // While the output stalls, the first and last pipeline valid bits stay unchanged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> ($stable(vld_q[0]) && $stable(vld_q[PIPE-1])))
    else $error("pipeline moved during output stall");

  // An item leaving the last stage lands in the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[PIPE-1] && s_axis_tready) |=> m_axis_tvalid)
    else $error("result lost at output register");
`endif

endmodule

`default_nettype wire
